// ----- rtl/core/mcd_pkg.sv -----
// Shared constants for the motion centroid detector.
// No dependencies; imported by mcd_front, mcd_back and the top module.
package mcd_pkg;

  localparam int DEF_FRAME_WIDTH  = 320;
  localparam int DEF_FRAME_HEIGHT = 240;

  localparam int PIX_W  = 8;   // pixel byte
  localparam int HIT_W  = 15;  // hit counter, also min_hits
  localparam int CX_W   = 9;   // center_x field
  localparam int CY_W   = 8;   // center_y field
  localparam int TDATA_OUT_W = 24;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_HITS       = 1'b1;

  localparam logic [PIX_W-1:0] RST_DIFF_THRESHOLD = 8'd30;
  localparam logic [HIT_W-1:0] RST_MIN_HITS       = 15'd50;

endpackage

// ----- rtl/core/mcd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mcd_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [ADDR_W-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]  wr_data_i,
  input  logic              rd_en_i,
  input  logic [ADDR_W-1:0] rd_addr_i,
  output logic [WIDTH-1:0]  rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/mcd_queue.sv -----
// Two-entry flop queue carrying frame totals from front to back.
// No package dependencies.
module mcd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       count_q;
  logic             push, pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/core/mcd_front.sv -----
// Pixel front end: raster position, previous-frame store, hit accumulation.
// Depends on mcd_pkg and mcd_ram; emits one totals job per compared frame.
module mcd_front #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240,
  parameter int JOB_W        = 62
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [mcd_pkg::PIX_W-1:0] pixel_i,
  input  logic                      last_i,
  input  logic [mcd_pkg::PIX_W-1:0] diff_threshold_i,
  output logic                      job_valid_o,
  input  logic                      job_ready_i,
  output logic [JOB_W-1:0]          job_data_o
);
  import mcd_pkg::*;

  localparam int CW     = $clog2(FRAME_WIDTH);
  localparam int RW     = $clog2(FRAME_HEIGHT);
  localparam int HALF_W = (FRAME_WIDTH + 1) / 2;
  localparam int HALF_H = (FRAME_HEIGHT + 1) / 2;
  localparam int DEPTH  = HALF_W * HALF_H;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SCW    = HIT_W + CW;
  localparam int SRW    = HIT_W + RW;

  // position of the next pixel
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  logic          accept, sampled;
  logic [AW-1:0] rd_addr;

  // compare stage
  logic             s1_valid_q, s1_last_q, s1_samp_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_col_q;
  logic [RW-1:0]    s1_row_q;
  logic [AW-1:0]    s1_addr_q;
  logic             s1_adv;
  logic             byp_q;
  logic [PIX_W-1:0] byp_pix_q;
  logic [PIX_W-1:0] ram_data, old_pix, diff;
  logic             first_q, hit;

  logic [HIT_W-1:0] hits_q, hits_d;
  logic [SCW-1:0]   sum_cols_q, sum_cols_d;
  logic [SRW-1:0]   sum_rows_q, sum_rows_d;

  assign accept  = s_axis_tvalid & s_axis_tready;
  assign sampled = ~col_q[0] & ~row_q[0];
  assign rd_addr = AW'(AW'(row_q >> 1) * AW'(HALF_W) + AW'(col_q >> 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept) begin
      if (last_i) begin
        col_q <= '0;
        row_q <= '0;
      end else if (col_q == CW'(FRAME_WIDTH - 1)) begin
        col_q <= '0;
        row_q <= (row_q == RW'(FRAME_HEIGHT - 1)) ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  mcd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH),
    .ADDR_W(AW)
  ) u_prev_frame (
    .clk_i    (clk_i),
    .wr_en_i  (s1_adv & s1_samp_q),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(s1_pix_q),
    .rd_en_i  (accept & sampled),
    .rd_addr_i(rd_addr),
    .rd_data_o(ram_data)
  );

  // stalls only when a frame total cannot enter the queue
  assign s1_adv        = s1_valid_q & ~(s1_last_q & ~first_q & ~job_ready_i);
  assign s_axis_tready = ~s1_valid_q | s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid_q <= 1'b1;
        // store write in flight to the same entry: forward it
        byp_q <= s1_adv & s1_samp_q & (s1_addr_q == rd_addr);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pix_q  <= pixel_i;
      s1_last_q <= last_i;
      s1_samp_q <= sampled;
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_addr_q <= rd_addr;
      byp_pix_q <= s1_pix_q;
    end
  end

  assign old_pix = byp_q ? byp_pix_q : ram_data;
  assign diff    = (s1_pix_q > old_pix) ? s1_pix_q - old_pix : old_pix - s1_pix_q;
  assign hit     = s1_samp_q & ~first_q & (diff > diff_threshold_i) & (hits_q != '1);

  assign hits_d     = hits_q + HIT_W'(hit);
  assign sum_cols_d = hit ? sum_cols_q + SCW'(s1_col_q) : sum_cols_q;
  assign sum_rows_d = hit ? sum_rows_q + SRW'(s1_row_q) : sum_rows_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q    <= 1'b1;
      hits_q     <= '0;
      sum_cols_q <= '0;
      sum_rows_q <= '0;
    end else if (s1_adv) begin
      if (s1_last_q) begin
        first_q    <= 1'b0;
        hits_q     <= '0;
        sum_cols_q <= '0;
        sum_rows_q <= '0;
      end else begin
        hits_q     <= hits_d;
        sum_cols_q <= sum_cols_d;
        sum_rows_q <= sum_rows_d;
      end
    end
  end

  assign job_valid_o = s1_valid_q & s1_last_q & ~first_q;
  assign job_data_o  = {sum_rows_d, sum_cols_d, hits_d};

endmodule

// ----- rtl/core/mcd_back.sv -----
// Back end: hit test and two parallel restoring dividers for the centroid.
// Depends on mcd_pkg; drives the result register of the output stream.
module mcd_back #(
  parameter int FRAME_WIDTH  = 320,
  parameter int FRAME_HEIGHT = 240,
  parameter int JOB_W        = 62
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            job_valid_i,
  output logic                            job_ready_o,
  input  logic [JOB_W-1:0]                job_data_i,
  input  logic [mcd_pkg::HIT_W-1:0]       min_hits_i,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mcd_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  output logic [0:0]                      m_axis_tuser
);
  import mcd_pkg::*;

  localparam int CW   = $clog2(FRAME_WIDTH);
  localparam int RW   = $clog2(FRAME_HEIGHT);
  localparam int SCW  = HIT_W + CW;
  localparam int SRW  = HIT_W + RW;
  localparam int DW   = (SCW > SRW) ? SCW : SRW;
  localparam int CNTW = $clog2(DW);
  localparam int XW   = CW + 1;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [HIT_W-1:0] job_hits;
  logic [SCW-1:0]   job_cols;
  logic [SRW-1:0]   job_rows;
  logic             job_motion, pop, load_out, out_free;

  logic             motion_q;
  logic [HIT_W-1:0] div_q;
  logic [DW-1:0]    num_c_q, num_r_q;
  logic [HIT_W-1:0] rem_c_q, rem_r_q;
  logic [CNTW-1:0]  cnt_q;
  logic [HIT_W:0]   trial_c, trial_r;
  logic             qc, qr;
  logic [XW-1:0]    cx;

  logic             out_valid_q, out_motion_q;
  logic [CX_W-1:0]  out_cx_q;
  logic [CY_W-1:0]  out_cy_q;

  assign {job_rows, job_cols, job_hits} = job_data_i;
  assign job_motion = (job_hits > min_hits_i) & (job_hits != '0);

  assign job_ready_o = (state_q == ST_IDLE);
  assign pop         = job_valid_i & job_ready_o;
  assign out_free    = ~out_valid_q | m_axis_tready;
  assign load_out    = (state_q == ST_DONE) & out_free;

  // one quotient bit per cycle on each divider
  assign trial_c = {rem_c_q, num_c_q[DW-1]};
  assign trial_r = {rem_r_q, num_r_q[DW-1]};
  assign qc      = (trial_c >= {1'b0, div_q});
  assign qr      = (trial_r >= {1'b0, div_q});

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (pop) state_d = job_motion ? ST_DIV : ST_DONE;
      ST_DIV:  if (cnt_q == CNTW'(DW - 1)) state_d = ST_DONE;
      ST_DONE: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      motion_q <= job_motion;
      div_q    <= job_hits;
      num_c_q  <= DW'(job_cols);
      num_r_q  <= DW'(job_rows);
      rem_c_q  <= '0;
      rem_r_q  <= '0;
      cnt_q    <= '0;
    end else if (state_q == ST_DIV) begin
      num_c_q <= {num_c_q[DW-2:0], qc};
      num_r_q <= {num_r_q[DW-2:0], qr};
      rem_c_q <= qc ? HIT_W'(trial_c - {1'b0, div_q}) : HIT_W'(trial_c);
      rem_r_q <= qr ? HIT_W'(trial_r - {1'b0, div_q}) : HIT_W'(trial_r);
      cnt_q   <= cnt_q + CNTW'(1);
    end
  end

  // mirrored column: width minus mean column
  assign cx = XW'(FRAME_WIDTH) - XW'(num_c_q[CW-1:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_motion_q <= motion_q;
      out_cx_q     <= motion_q ? CX_W'(cx) : '0;
      out_cy_q     <= motion_q ? CY_W'(num_r_q[RW-1:0]) : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_motion_q;
  assign m_axis_tdata  = TDATA_OUT_W'({out_cy_q, out_cx_q});

endmodule

// ----- rtl/core/motion_centroid_detector_top.sv -----
// Motion centroid detector: pixel front end, totals queue, divider back end.
// Throughput: one pixel item per cycle; stalls only when two frame results are queued.
// Flow: a pixel is compared in the cycle after acceptance; a frame result passes
//   from the last pixel through the totals queue and the bit-serial centroid dividers
//   into the registered output stream.
// Reset (async, active low): position, sums, queue, output cleared; first frame pending;
//   thresholds 30 and 50. The frame store holds no reset value; the first frame fills it.
module motion_centroid_detector_top #(
  parameter int FRAME_WIDTH  = mcd_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = mcd_pkg::DEF_FRAME_HEIGHT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // pixel stream in
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [mcd_pkg::PIX_W-1:0]       s_axis_tdata,  // [7:0] pixel_value
  input  logic                            s_axis_tlast,  // frame_end
  // result stream out
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [mcd_pkg::TDATA_OUT_W-1:0] m_axis_tdata,  // [8:0] center_x, [16:9] center_y
  output logic [0:0]                      m_axis_tuser,  // [0] motion_found
  // register writes
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mcd_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [mcd_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import mcd_pkg::*;

  localparam int CW    = $clog2(FRAME_WIDTH);
  localparam int RW    = $clog2(FRAME_HEIGHT);
  // job: {sum_rows, sum_cols, hit_count}
  localparam int JOB_W = HIT_W + (HIT_W + CW) + (HIT_W + RW);

  logic [PIX_W-1:0] diff_threshold_q;
  logic [HIT_W-1:0] min_hits_q;

  logic             fj_valid, fj_ready, bj_valid, bj_ready;
  logic [JOB_W-1:0] fj_data, bj_data;

  // Registers accept a write every cycle; the block must be idle while written, which it does not enforce.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      diff_threshold_q <= RST_DIFF_THRESHOLD;
      min_hits_q       <= RST_MIN_HITS;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_DIFF_THRESHOLD: diff_threshold_q <= cfg_data_i[PIX_W-1:0];
        CFG_MIN_HITS:       min_hits_q       <= cfg_data_i[HIT_W-1:0];
        default:            ;
      endcase
    end
  end

  // Front: one pixel per cycle unless the queue is full at frame end; compares against
  // the stored previous frame, builds the hit totals; the last pixel pushes them as a job.
  mcd_front #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .JOB_W       (JOB_W)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid   (s_axis_tvalid),
    .s_axis_tready   (s_axis_tready),
    .pixel_i         (s_axis_tdata),
    .last_i          (s_axis_tlast),
    .diff_threshold_i(diff_threshold_q),
    .job_valid_o     (fj_valid),
    .job_ready_i     (fj_ready),
    .job_data_o      (fj_data)
  );

  // Two jobs of slack so the division overlaps the next frame's pixels.
  mcd_queue #(
    .WIDTH(JOB_W)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fj_valid),
    .push_ready_o(fj_ready),
    .push_data_i (fj_data),
    .pop_valid_o (bj_valid),
    .pop_ready_i (bj_ready),
    .pop_data_o  (bj_data)
  );

  // Back: min-hit test, then mean row and column by serial division.
  mcd_back #(
    .FRAME_WIDTH (FRAME_WIDTH),
    .FRAME_HEIGHT(FRAME_HEIGHT),
    .JOB_W       (JOB_W)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .job_valid_i  (bj_valid),
    .job_ready_o  (bj_ready),
    .job_data_i   (bj_data),
    .min_hits_i   (min_hits_q),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

endmodule
